@@ hw/rtl/mcp_pkg.sv @@
// ----------------------------------------------------------------------------
// mcp_pkg: shared types and constants of the metronome click player
// Request codes, configuration register indexes and reset defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package mcp_pkg;

  // Request codes carried by in_req_type
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_LOAD  = 2'd3
  } req_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_GAIN          = 2'd0,
    CFG_CLICK_PERIOD  = 2'd1,
    CFG_SAMPLE_LENGTH = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_t;

  // Field widths fixed by the register map
  localparam int unsigned GAIN_W    = 9;
  localparam int unsigned PERIOD_W  = 40;
  localparam int unsigned LENGTH_W  = 17;
  localparam int unsigned ADDR_IN_W = 16;
  localparam int unsigned ELAPSED_W = 48;
  localparam int unsigned CLICK_T_W = 64;
  localparam int unsigned CFG_W     = 40;

  // Reset values
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 9'd256;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 40'd2359296000;

  // Default parameter values
  localparam int unsigned DEF_STORE_DEPTH          = 65536;
  localparam int unsigned DEF_SAMPLE_BITS          = 16;
  localparam int unsigned DEF_PERIOD_FRACTION_BITS = 16;

endpackage

`default_nettype wire

@@ hw/rtl/metronome_click_player.sv @@
// ----------------------------------------------------------------------------
// metronome_click_player: metronome click sample retrigger
// Plays a stored mono click, scaled by a gain, to both stereo outputs, and
// restarts it at a fractional click period.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request per transaction:
//   frame tick, start, stop, or load one click sample word. Only a frame tick
//   produces a result transaction on the output channel (out_valid/out_ready),
//   with out_left equal to out_right; while stopped the result is zero.
//   Configuration (cfg_valid/cfg_ready, always ready) writes gain, click
//   period and sample length; write it only while no transaction is in flight.
// Throughput:
//   One request is taken every cycle while the output is not stalled: the
//   click memory is read at the play position in the accept cycle, the
//   multiply by gain follows, then rounding and saturation into the output
//   register, which drives out_valid.
// Reset:
//   rst_n (synchronous, active low) stops playback, clears position and
//   elapsed count and restores the register defaults. The click memory is not
//   cleared; no clearing pass runs. Entries read before being loaded are
//   undefined.
// Stall:
//   When the output register holds a result that is not taken, the whole
//   pipeline holds and in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module metronome_click_player #(
  parameter int unsigned STORE_DEPTH          = mcp_pkg::DEF_STORE_DEPTH,
  parameter int unsigned SAMPLE_BITS          = mcp_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned PERIOD_FRACTION_BITS = mcp_pkg::DEF_PERIOD_FRACTION_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // request channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           in_req_type,
  input  wire logic [mcp_pkg::ADDR_IN_W-1:0]        in_load_addr,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_load_value,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]             out_left,
  output logic signed [SAMPLE_BITS-1:0]             out_right,
  // configuration write channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [1:0]                           cfg_index,
  input  wire logic [mcp_pkg::CFG_W-1:0]            cfg_data
);

  localparam int unsigned ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned LEN_W   = mcp_pkg::LENGTH_W;
  localparam int unsigned EL_W    = mcp_pkg::ELAPSED_W;
  localparam int unsigned CT_W    = mcp_pkg::CLICK_T_W;
  localparam int unsigned PROD_W  = SAMPLE_BITS + 10;
  localparam int unsigned Q_W     = SAMPLE_BITS + 2;
  localparam int unsigned FRM_W   = CT_W + 1;
  localparam int unsigned RND_IDX = (PERIOD_FRACTION_BITS == 0) ? 0 : PERIOD_FRACTION_BITS - 1;

  localparam logic signed [Q_W-1:0]    Q_MAX = Q_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [Q_W-1:0]    Q_MIN = Q_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
  localparam logic signed [PROD_W-1:0] HALF  = PROD_W'(128);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [mcp_pkg::GAIN_W-1:0]   gain_r,   gain_nxt;
  logic [mcp_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic [LEN_W-1:0]             length_r, length_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    gain_nxt   = gain_r;
    period_nxt = period_r;
    length_nxt = length_r;
    if (cfg_valid) begin
      case (cfg_index)
        mcp_pkg::CFG_GAIN:          gain_nxt   = cfg_data[mcp_pkg::GAIN_W-1:0];
        mcp_pkg::CFG_CLICK_PERIOD:  period_nxt = cfg_data[mcp_pkg::PERIOD_W-1:0];
        mcp_pkg::CFG_SAMPLE_LENGTH: length_nxt = cfg_data[LEN_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= mcp_pkg::GAIN_RESET;
      period_r <= mcp_pkg::PERIOD_RESET;
      length_r <= '0;
    end else begin
      gain_r   <= gain_nxt;
      period_r <= period_nxt;
      length_r <= length_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: every stage moves together unless the result is stuck
  // --------------------------------------------------------------------------
  logic out_valid_r, out_valid_nxt;
  logic advance;
  logic accept;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  // --------------------------------------------------------------------------
  // Stage 0: request decode and playback state update
  // --------------------------------------------------------------------------
  logic             running_r, running_nxt;
  logic [LEN_W-1:0] pos_r,     pos_nxt;
  logic [EL_W-1:0]  elapsed_r, elapsed_nxt;
  logic [CT_W-1:0]  click_t_r, click_t_nxt;

  logic             is_tick;
  logic             is_load;
  logic [LEN_W-1:0] len_eff;
  logic             pos_hit;
  logic             play;
  logic [EL_W-1:0]  elapsed_inc;
  logic [FRM_W-1:0] click_frame;
  logic             round_bit;
  logic             click_due;
  logic             load_in_range;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign is_tick = accept && (in_req_type == mcp_pkg::REQ_TICK);
  assign is_load = accept && (in_req_type == mcp_pkg::REQ_LOAD);

  // Clamp the sample length to the store size
  assign len_eff = ({15'd0, length_r} > 32'(STORE_DEPTH)) ? LEN_W'(STORE_DEPTH) : length_r;
  assign pos_hit = pos_r < len_eff;
  assign play    = running_r && pos_hit;

  // Round the click-time accumulator to the nearest whole frame
  assign round_bit   = (PERIOD_FRACTION_BITS != 0) && click_t_r[RND_IDX];
  assign click_frame = FRM_W'(click_t_r >> PERIOD_FRACTION_BITS) + FRM_W'(round_bit);
  assign elapsed_inc = elapsed_r + EL_W'(1);
  assign click_due   = FRM_W'(elapsed_inc) >= click_frame;

  assign load_in_range = {16'd0, in_load_addr} < 32'(STORE_DEPTH);
  assign wr_addr       = ADDR_W'(in_load_addr);
  assign rd_addr       = ADDR_W'(pos_r);

  always_comb begin
    running_nxt = running_r;
    pos_nxt     = pos_r;
    elapsed_nxt = elapsed_r;
    click_t_nxt = click_t_r;
    if (accept) begin
      case (in_req_type)
        mcp_pkg::REQ_START: begin
          pos_nxt     = '0;
          elapsed_nxt = '0;
          click_t_nxt = CT_W'(period_r);
          running_nxt = 1'b1;
        end
        mcp_pkg::REQ_STOP: begin
          running_nxt = 1'b0;
        end
        mcp_pkg::REQ_TICK: begin
          if (running_r) begin
            // advance the play position, then retrigger on a due click
            if (pos_hit) begin
              pos_nxt = pos_r + LEN_W'(1);
            end
            elapsed_nxt = elapsed_inc;
            if (click_due) begin
              pos_nxt     = '0;
              click_t_nxt = click_t_r + CT_W'(period_r);
            end
          end
        end
        default: ;  // load: store write only
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      pos_r     <= '0;
      elapsed_r <= '0;
      click_t_r <= CT_W'(mcp_pkg::PERIOD_RESET);
    end else begin
      running_r <= running_nxt;
      pos_r     <= pos_nxt;
      elapsed_r <= elapsed_nxt;
      click_t_r <= click_t_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Click memory: one write port for loads, one registered read port for
  // ticks. Only one request enters per cycle, so a load and a later tick to
  // the same entry never overlap in the same cycle.
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] click_mem [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] mem_q_r;

  always_ff @(posedge clk) begin
    if (is_load && load_in_range) begin
      click_mem[wr_addr] <= in_load_value;
    end
    if (is_tick) begin
      mem_q_r <= click_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: sample arrives from memory, scale by gain
  // --------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic s1_play_r;
  logic s2_valid_r, s2_valid_nxt;
  logic s2_play_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [9:0]        gain_s;

  assign gain_s       = signed'({1'b0, gain_r});
  assign prod_nxt     = PROD_W'(mem_q_r) * PROD_W'(gain_s);
  assign s1_valid_nxt = advance ? is_tick : s1_valid_r;
  assign s2_valid_nxt = advance ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_play_r <= play;
      s2_play_r <= s1_play_r;
      prod_r    <= prod_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: round half up, saturate, load the output register
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0]      rounded;
  logic signed [Q_W-1:0]         quot;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic signed [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;

  assign rounded = prod_r + HALF;
  assign quot    = Q_W'(rounded >>> 8);

  always_comb begin
    if (quot > Q_MAX) begin
      sat = SAMPLE_BITS'(Q_MAX);
    end else if (quot < Q_MIN) begin
      sat = SAMPLE_BITS'(Q_MIN);
    end else begin
      sat = SAMPLE_BITS'(quot);
    end
  end

  assign out_sample_nxt = advance ? (s2_play_r ? sat : '0) : out_sample_r;
  assign out_valid_nxt  = advance ? s2_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_sample_r;
  assign out_right = out_sample_r;

endmodule

`default_nettype wire

@@ test/metronome_click_player_checker.sv @@
// ----------------------------------------------------------------------------
// metronome_click_player_checker: click player scoreboard
// Watches the request, result and configuration channels, predicts every
// frame-tick sample from a local copy of the player state, and compares each
// result transaction with the oldest predicted sample.
// ----------------------------------------------------------------------------
module metronome_click_player_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic                               in_ready,
  input  wire logic [1:0]                         in_req_type,
  input  wire logic [mcp_pkg::ADDR_IN_W-1:0]      in_load_addr,
  input  wire logic signed [mcp_pkg::DEF_SAMPLE_BITS-1:0] in_load_value,
  input  wire logic                               out_valid,
  input  wire logic                               out_ready,
  input  wire logic signed [mcp_pkg::DEF_SAMPLE_BITS-1:0] out_left,
  input  wire logic signed [mcp_pkg::DEF_SAMPLE_BITS-1:0] out_right,
  input  wire logic                               cfg_valid,
  input  wire logic                               cfg_ready,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [mcp_pkg::CFG_W-1:0]          cfg_data,
  output int unsigned                             mismatch_count,
  output int unsigned                             samples_pending
);
  import mcp_pkg::*;

  localparam int unsigned SAMPLE_W  = DEF_SAMPLE_BITS;
  localparam int unsigned STORE_N   = DEF_STORE_DEPTH;
  localparam int unsigned FRAC_BITS = DEF_PERIOD_FRACTION_BITS;
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  logic signed [SAMPLE_W-1:0]  click_mem [0:STORE_N-1];
  logic [LENGTH_W-1:0]         play_pos;
  logic [ELAPSED_W-1:0]        frames_elapsed;
  logic [CLICK_T_W-1:0]        click_due;
  logic                        playing;
  logic [GAIN_W-1:0]           gain_q;
  logic [PERIOD_W-1:0]         period_q;
  logic [LENGTH_W-1:0]         length_q;
  logic signed [SAMPLE_W-1:0]  expected_samples [$];
  int unsigned                 failures;

  // Round half up after the Q1.8 gain, then clamp to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] scaled_sample(
    input logic signed [SAMPLE_W-1:0] raw,
    input logic [GAIN_W-1:0]          gain
  );
    longint acc;
    acc = (longint'(raw) * longint'(gain) + 128) >>> 8;
    if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
    else if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
    return acc[SAMPLE_W-1:0];
  endfunction

  // Click time rounded to the nearest whole frame.
  function automatic logic [CLICK_T_W-1:0] nearest_frame(input logic [CLICK_T_W-1:0] t);
    return (t >> FRAC_BITS) + t[FRAC_BITS-1];
  endfunction

  always @(posedge clk) begin : watch
    int unsigned                usable;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      play_pos       = '0;
      frames_elapsed = '0;
      click_due      = CLICK_T_W'(PERIOD_RESET);
      playing        = 1'b0;
      gain_q         = GAIN_RESET;
      period_q       = PERIOD_RESET;
      length_q       = '0;
      failures       = 0;
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_GAIN:          gain_q   = cfg_data[GAIN_W-1:0];
          CFG_CLICK_PERIOD:  period_q = cfg_data[PERIOD_W-1:0];
          CFG_SAMPLE_LENGTH: length_q = cfg_data[LENGTH_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        case (req_t'(in_req_type))
          REQ_START: begin
            play_pos       = '0;
            frames_elapsed = '0;
            click_due      = CLICK_T_W'(period_q);
            playing        = 1'b1;
          end
          REQ_STOP: playing = 1'b0;
          REQ_LOAD: click_mem[in_load_addr] = in_load_value;
          default: begin
            sample = '0;
            if (playing) begin
              usable = (length_q > STORE_N) ? STORE_N : length_q;
              if (play_pos < usable) begin
                sample   = scaled_sample(click_mem[play_pos[ADDR_IN_W-1:0]], gain_q);
                play_pos = play_pos + 1'b1;
              end
              frames_elapsed = frames_elapsed + 1'b1;
              if (frames_elapsed >= nearest_frame(click_due)) begin
                play_pos  = '0;
                click_due = click_due + period_q;
              end
            end
            expected_samples.push_back(sample);
          end
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("result with no frame tick waiting: out_left %0d, out_right %0d",
                 out_left, out_right);
          failures++;
        end else begin
          want = expected_samples.pop_front();
          if (out_left !== want) begin
            $error("out_left: expected %0d, actual %0d", want, out_left);
            failures++;
          end
          if (out_right !== want) begin
            $error("out_right: expected %0d, actual %0d", want, out_right);
            failures++;
          end
        end
      end
    end
    mismatch_count  <= failures;
    samples_pending <= expected_samples.size();
  end

endmodule

@@ test/metronome_click_player_tb.sv @@
// ----------------------------------------------------------------------------
// metronome_click_player_tb: metronome click player testbench
// Drives frame ticks, start, stop and click loads through the request channel
// under random sender bursts and receiver stalls, reprograms gain, click
// period and sample length between phases, and leaves the sample checks to a
// scoreboard module that runs beside the player.
// ----------------------------------------------------------------------------
module metronome_click_player_tb;
  import mcp_pkg::*;

  localparam int unsigned SAMPLE_W       = DEF_SAMPLE_BITS;
  localparam int unsigned STORE_N        = DEF_STORE_DEPTH;
  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RANDOM_ITEMS   = 1000;
  // Let the pipeline run empty before a config is written.
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TIMEOUT_CYCLES = 600000;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX  = '1;
  localparam logic [PERIOD_W-1:0] ONE_FRAME   = PERIOD_W'(1) << DEF_PERIOD_FRACTION_BITS;
  localparam logic [PERIOD_W-1:0] HALF_FRAME  = ONE_FRAME >> 1;

  typedef enum int unsigned {
    READY_ALWAYS,
    READY_COIN,
    READY_QUARTER,
    READY_BURSTY
  } ready_mode_t;

  logic                       clk           = 1'b0;
  logic                       rst_n         = 1'b0;
  logic                       in_valid      = 1'b0;
  logic                       in_ready;
  logic [1:0]                 in_req_type   = REQ_TICK;
  logic [ADDR_IN_W-1:0]       in_load_addr  = '0;
  logic signed [SAMPLE_W-1:0] in_load_value = '0;
  logic                       out_valid;
  logic                       out_ready     = 1'b0;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic                       cfg_valid     = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index     = CFG_GAIN;
  logic [CFG_W-1:0]           cfg_data      = '0;
  int unsigned                mismatch_count;
  int unsigned                samples_pending;

  // Stimulus bookkeeping: which click entries hold data, and a bound on how
  // far the play position can have run since the last start. Ticks are only
  // sent when every entry they might read has been loaded.
  bit          loaded [0:STORE_N-1];
  int unsigned loaded_prefix  = 0;
  bit          playing        = 1'b0;
  int unsigned pos_ceiling    = 0;
  int unsigned length_setting = 0;
  int unsigned burst_left     = 0;
  bit          steady         = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  metronome_click_player u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_load_addr  (in_load_addr),
    .in_load_value (in_load_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_left      (out_left),
    .out_right     (out_right),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  metronome_click_player_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_load_addr    (in_load_addr),
    .in_load_value   (in_load_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left        (out_left),
    .out_right       (out_right),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .samples_pending (samples_pending)
  );

  // Receiver: pick a new stall behavior at random at regular intervals so stalls
  // land on every pipeline phase, with always-ready stretches in between.
  ready_mode_t ready_mode  = READY_ALWAYS;
  int unsigned stall_left  = 0;
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 128 == 0) ready_mode = ready_mode_t'($urandom_range(0, 3));
    case (ready_mode)
      READY_ALWAYS:  out_ready <= 1'b1;
      READY_COIN:    out_ready <= 1'($urandom_range(0, 1));
      READY_QUARTER: out_ready <= (cycle_count % 4 == 0);
      default: begin
        if (stall_left == 0 && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
        if (stall_left != 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  function automatic int unsigned usable_length();
    return (length_setting > STORE_N) ? STORE_N : length_setting;
  endfunction

  // Send one request transaction. Open a random gap at the end of each burst
  // unless this phase runs without idling; hold valid and payload until taken.
  task automatic send_request(
    input req_t                 req,
    input logic [ADDR_IN_W-1:0] addr,
    input logic [SAMPLE_W-1:0]  value
  );
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_load_addr  <= addr;
    in_load_value <= value;
    do @(posedge clk); while (!in_ready);

    case (req)
      REQ_START: begin
        playing     = 1'b1;
        pos_ceiling = 0;
      end
      REQ_STOP: playing = 1'b0;
      REQ_LOAD: begin
        loaded[addr] = 1'b1;
        while (loaded_prefix < STORE_N && loaded[loaded_prefix]) loaded_prefix++;
      end
      default: if (playing && pos_ceiling < usable_length()) pos_ceiling++;
    endcase
  endtask

  // Mostly running ticks over a click that is filled front to back, plus
  // noise loads anywhere, overwrites, restarts and stops.
  task automatic random_request();
    int unsigned          pick;
    int unsigned          reach;
    req_t                 req;
    logic [ADDR_IN_W-1:0] addr;
    logic [SAMPLE_W-1:0]  value;
    pick  = $urandom_range(0, 99);
    addr  = ADDR_IN_W'($urandom);
    value = SAMPLE_W'($urandom);
    if (pick < 62) req = REQ_TICK;
    else if (pick < 84) req = REQ_LOAD;
    else if (pick < 92) req = REQ_START;
    else req = REQ_STOP;

    if (req == REQ_LOAD && pick < 72 && loaded_prefix < STORE_N) begin
      addr = loaded_prefix[ADDR_IN_W-1:0];
    end else if (req == REQ_LOAD && pick >= 80 && loaded_prefix > 0) begin
      addr = ADDR_IN_W'($urandom_range(0, loaded_prefix - 1));
    end

    // Turn a tick that could reach an unloaded entry into the next fill load.
    reach = (pos_ceiling + 1 < usable_length()) ? pos_ceiling + 1 : usable_length();
    if (req == REQ_TICK && playing && reach > loaded_prefix) begin
      req  = REQ_LOAD;
      addr = loaded_prefix[ADDR_IN_W-1:0];
    end
    send_request(req, addr, value);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all three registers; fill the bits above each register with junk.
  task automatic program_player(
    input logic [GAIN_W-1:0]   gain,
    input logic [PERIOD_W-1:0] period,
    input logic [LENGTH_W-1:0] length
  );
    logic [CFG_W-1:0] junk;
    junk = CFG_W'({$urandom, $urandom});
    write_register(CFG_GAIN, {junk[CFG_W-1:GAIN_W], gain});
    write_register(CFG_CLICK_PERIOD, period);
    write_register(CFG_SAMPLE_LENGTH, {junk[CFG_W-1:LENGTH_W], length});
    cfg_valid <= 1'b0;
    length_setting = length;
  endtask

  // Drop valid, wait for every predicted sample to come out, then let the
  // pipeline run empty before anything is reprogrammed.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (samples_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned         random_sent;
    int unsigned         phase;
    int unsigned         phase_items;
    logic [GAIN_W-1:0]   gain;
    logic [PERIOD_W-1:0] period;
    logic [LENGTH_W-1:0] length;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: a tick while stopped, extreme click words, then play
    // with zero sample length.
    send_request(REQ_TICK,  16'h0000, 16'h0000);
    send_request(REQ_LOAD,  16'h0000, 16'h8000);
    send_request(REQ_LOAD,  16'h0001, 16'h7FFF);
    send_request(REQ_LOAD,  16'h0002, 16'hFFFF);
    send_request(REQ_LOAD,  16'h0003, 16'h0001);
    send_request(REQ_LOAD,  16'hFFFF, 16'h5A5A);
    send_request(REQ_START, 16'hFFFF, 16'hFFFF);
    send_request(REQ_TICK,  16'hFFFF, 16'hFFFF);
    send_request(REQ_STOP,  16'h0000, 16'h0000);
    send_request(REQ_TICK,  16'h0000, 16'h0000);
    quiesce();

    // Top gain saturates both ways; a 3.5-frame period exercises the
    // round-half-up click time. Restart while already playing.
    write_register(CFG_UNUSED, CFG_W'({$urandom, $urandom}));
    program_player(9'd511, 3 * ONE_FRAME + HALF_FRAME, 17'd4);
    send_request(REQ_START, 16'h0000, 16'h0000);
    repeat (7) send_request(REQ_TICK, 16'h0000, 16'h0000);
    send_request(REQ_START, 16'h0000, 16'h0000);
    send_request(REQ_TICK,  16'h0000, 16'h0000);
    send_request(REQ_STOP,  16'h0000, 16'h0000);
    send_request(REQ_TICK,  16'h0000, 16'h0000);
    quiesce();

    // Zero gain, zero period (click restarts every frame) and a sample length
    // past the end of the store.
    program_player(9'd0, '0, '1);
    send_request(REQ_START, 16'h0000, 16'h0000);
    repeat (3) send_request(REQ_TICK, 16'h0000, 16'h0000);
    quiesce();

    // Random phases: new settings, a start, then a random mix of requests.
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          gain   = 9'd255;
          period = ONE_FRAME;
          length = 17'd65536;
        end
        1: begin
          gain   = 9'd257;
          period = PERIOD_MAX;
          length = 17'd1;
        end
        default: begin
          case ($urandom_range(0, 7))
            0:       gain = 9'd0;
            1:       gain = 9'd511;
            2:       gain = 9'd256;
            3:       gain = 9'd255;
            default: gain = GAIN_W'($urandom_range(0, 511));
          endcase
          case ($urandom_range(0, 7))
            0:       period = '0;
            1:       period = ONE_FRAME;
            2:       period = PERIOD_MAX;
            3:       period = ONE_FRAME * $urandom_range(1, 8);
            4:       period = ONE_FRAME * $urandom_range(0, 8) + HALF_FRAME;
            default: period = PERIOD_W'($urandom_range(ONE_FRAME, 64 * ONE_FRAME));
          endcase
          case ($urandom_range(0, 7))
            0:       length = 17'd0;
            1:       length = 17'd1;
            2:       length = 17'd65536;
            3:       length = LENGTH_W'($urandom_range(65537, 131071));
            default: length = LENGTH_W'($urandom_range(2, 300));
          endcase
        end
      endcase
      steady = ($urandom_range(0, 3) == 0);
      program_player(gain, period, length);
      send_request(REQ_START, ADDR_IN_W'($urandom), SAMPLE_W'($urandom));
      phase_items = $urandom_range(60, 140);
      repeat (phase_items) begin
        random_request();
        random_sent++;
      end
      quiesce();
      phase++;
    end

    if (mismatch_count == 0) begin
      $display("metronome_click_player_tb: clean");
    end else begin
      $display("metronome_click_player_tb: errors");
    end
    $finish;
  end

  // Hard stop if the player hangs or results never drain.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("metronome_click_player_tb: errors");
    $finish;
  end

endmodule

@@ metronome_click_player.f @@
hw/rtl/mcp_pkg.sv
hw/rtl/metronome_click_player.sv
test/metronome_click_player_checker.sv
test/metronome_click_player_tb.sv
